@@ hw/rtl/bucket_averaging_history_ring_defines.svh @@
// Assertion helpers shared by the RTL; clk and arst_n are taken from the scope of use.
`ifndef BUCKET_AVERAGING_HISTORY_RING_DEFINES_SVH
`define BUCKET_AVERAGING_HISTORY_RING_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define BAHR_ASSERT_SAME(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("bahr assertion failed");

// condition holds in the cycle after the trigger
`define BAHR_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("bahr assertion failed");

`endif

@@ hw/rtl/bahr_pkg.sv @@
`timescale 1ns / 1ps

package bahr_pkg;

	localparam int SLOTS      = 240;
	localparam int COUNT_BITS = 16;
	localparam int PTR_W      = $clog2(SLOTS);

	// running sums hold (2^COUNT_BITS - 1) full-scale samples without wrapping
	localparam int CSUM_W = 16 + COUNT_BITS;
	localparam int TSUM_W = 16 + COUNT_BITS;
	localparam int HSUM_W = 14 + COUNT_BITS;
	localparam int DIVD_W = 16 + COUNT_BITS;
	localparam int DCNT_W = $clog2(DIVD_W + 1);

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_IGNORED = 2'd1;
	localparam logic [1:0] STAT_RANGE   = 2'd2;

	typedef struct packed {
		logic        [13:0] humid;
		logic signed [15:0] temp;
		logic        [15:0] co2;
	} rec_t;

	typedef struct packed {
		logic                  start;
		logic [DIVD_W-1:0]     dividend;
		logic [COUNT_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ hw/rtl/bahr_div.sv @@
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
module bahr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bahr_pkg::div_req_t req,
	output bahr_pkg::div_rsp_t rsp
);

	logic [bahr_pkg::COUNT_BITS-1:0] rem_q;
	logic [bahr_pkg::COUNT_BITS-1:0] dsr_q;
	logic [bahr_pkg::DIVD_W-1:0]     quo_q;
	logic [bahr_pkg::DCNT_W-1:0]     cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [bahr_pkg::COUNT_BITS:0]   trial;
	logic                            fits;

	assign trial = {rem_q, quo_q[bahr_pkg::DIVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == bahr_pkg::DCNT_W'(1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= bahr_pkg::DCNT_W'(bahr_pkg::DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == bahr_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= bahr_pkg::COUNT_BITS'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[bahr_pkg::COUNT_BITS-1:0];
			end
			quo_q <= {quo_q[bahr_pkg::DIVD_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ hw/rtl/bucket_averaging_history_ring.sv @@
`timescale 1ns / 1ps
// Flow: load, clear, ignored and out-of-range requests go from idle straight to S_DONE; a
// read passes S_READ first. A sample first walks S_ZERO over each skipped slot (up to 239)
// when it opens a new bucket after an earlier one, then runs three 32-step serial divisions
// and S_WRITE. One request at a time: a new request is taken only in S_IDLE.
// Reset: asynchronous active low; slot valid bits, pointer, bucket, count clear at once.
module bucket_averaging_history_ring (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// bucket[7:0], time_valid[8], slot_index[16:9], co2_ppm[32:17],
	// temp_centi[48:33], humid_centi[62:49], zero[63]
	input  logic [63:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_co2[15:0], out_temp[31:16], out_humid[45:32], zero[47:46]
	output logic [47:0] m_axis_tdata,
	// status[1:0]
	output logic [1:0]  m_axis_tuser
);

	`include "bucket_averaging_history_ring_defines.svh"

	localparam int PW = bahr_pkg::PTR_W;
	localparam int CB = bahr_pkg::COUNT_BITS;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ZERO     = 3'd1;
	localparam logic [2:0] S_DIV_GO   = 3'd2;
	localparam logic [2:0] S_DIV_WAIT = 3'd3;
	localparam logic [2:0] S_WRITE    = 3'd4;
	localparam logic [2:0] S_READ     = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	localparam logic [1:0] DSEL_CO2   = 2'd0;
	localparam logic [1:0] DSEL_TEMP  = 2'd1;
	localparam logic [1:0] DSEL_HUMID = 2'd2;

	localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};
	localparam logic [PW-1:0] LAST_SLOT = PW'(bahr_pkg::SLOTS - 1);

	// request fields
	logic [1:0]         cmd;
	logic [7:0]         bkt;
	logic               tv;
	logic [7:0]         idx;
	logic [15:0]        co2_in;
	logic signed [15:0] temp_in;
	logic [13:0]        humid_in;

	assign cmd      = s_axis_tuser;
	assign bkt      = s_axis_tdata[7:0];
	assign tv       = s_axis_tdata[8];
	assign idx      = s_axis_tdata[16:9];
	assign co2_in   = s_axis_tdata[32:17];
	assign temp_in  = s_axis_tdata[48:33];
	assign humid_in = s_axis_tdata[62:49];

	logic [2:0]                     state_q;
	logic [PW-1:0]                  wp_q;
	logic [PW-1:0]                  cur_q;
	logic                           known_q;
	logic [bahr_pkg::CSUM_W-1:0]    co2_sum_q;
	logic signed [bahr_pkg::TSUM_W-1:0] temp_sum_q;
	logic [bahr_pkg::HSUM_W-1:0]    humid_sum_q;
	logic [CB-1:0]                  count_q;
	logic [PW-1:0]                  zcnt_q;
	logic [1:0]                     dsel_q;
	logic                           tneg_q;
	bahr_pkg::rec_t                 mean_q;
	bahr_pkg::rec_t                 res_rec_q;
	logic [1:0]                     res_stat_q;
	bahr_pkg::rec_t                 out_rec_q;
	logic [1:0]                     out_stat_q;
	logic                           out_valid_q;
	logic [bahr_pkg::SLOTS-1:0]     valid_q;

	// slot memory
	bahr_pkg::rec_t mem [bahr_pkg::SLOTS];
	bahr_pkg::rec_t rd_data_s1;
	logic           rd_valid_s1;
	logic           mem_we;
	logic [PW-1:0]  mem_waddr;
	bahr_pkg::rec_t mem_wdata;
	logic           mem_re;
	logic [PW-1:0]  mem_raddr;

	bahr_pkg::div_req_t div_req;
	bahr_pkg::div_rsp_t div_rsp;

	logic          acc;
	logic          ignore;
	logic          same_bkt;
	logic          idx_bad;
	logic [PW:0]   rd_sum;
	logic [PW-1:0] diff;
	logic [PW-1:0] latest;
	logic [PW-1:0] wp_next;
	logic [PW-1:0] bkt_p;
	logic [bahr_pkg::TSUM_W-1:0] temp_mag;
	logic [15:0]   tq;

	assign acc      = s_axis_tvalid && s_axis_tready;
	assign bkt_p    = bkt[PW-1:0];
	assign ignore   = (co2_in == 16'd0) || !tv || (bkt >= bahr_pkg::SLOTS);
	assign same_bkt = known_q && (bkt_p == cur_q);
	assign idx_bad  = idx >= bahr_pkg::SLOTS;

	// forward bucket distance, both buckets below SLOTS
	assign diff = (bkt_p >= cur_q) ? PW'(bkt_p - cur_q)
	                               : PW'((PW+1)'(bahr_pkg::SLOTS) - {1'b0, cur_q} + {1'b0, bkt_p});

	// oldest slot sits at the write pointer
	assign rd_sum    = {1'b0, wp_q} + {1'b0, idx[PW-1:0]};
	assign mem_raddr = (rd_sum >= bahr_pkg::SLOTS) ? PW'(rd_sum - (PW+1)'(bahr_pkg::SLOTS))
	                                               : rd_sum[PW-1:0];
	assign mem_re    = (state_q == S_IDLE) && acc && (cmd == bahr_pkg::CMD_READ) && !idx_bad;

	assign latest  = (wp_q == '0) ? LAST_SLOT : PW'(wp_q - 1'b1);
	assign wp_next = (wp_q == LAST_SLOT) ? '0 : PW'(wp_q + 1'b1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = latest;
		mem_wdata = mean_q;
		if ((state_q == S_IDLE) && acc && (cmd == bahr_pkg::CMD_LOAD) && !idx_bad) begin
			mem_we         = 1'b1;
			mem_waddr      = idx[PW-1:0];
			mem_wdata.co2  = co2_in;
			mem_wdata.temp = temp_in;
			mem_wdata.humid = humid_in;
		end else if (state_q == S_WRITE) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1  <= mem[mem_raddr];
			rd_valid_s1 <= valid_q[mem_raddr];
		end
	end

	// divider operands
	assign temp_mag = temp_sum_q[bahr_pkg::TSUM_W-1] ? bahr_pkg::TSUM_W'(-temp_sum_q)
	                                                 : bahr_pkg::TSUM_W'(temp_sum_q);

	always_comb begin
		div_req.start   = state_q == S_DIV_GO;
		div_req.divisor = count_q;
		case (dsel_q)
			DSEL_CO2:   div_req.dividend = bahr_pkg::DIVD_W'(co2_sum_q);
			DSEL_TEMP:  div_req.dividend = bahr_pkg::DIVD_W'(temp_mag);
			DSEL_HUMID: div_req.dividend = bahr_pkg::DIVD_W'(humid_sum_q);
			default:    div_req.dividend = '0;
		endcase
	end

	bahr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign tq = tneg_q ? 16'(-div_rsp.quotient[15:0]) : div_rsp.quotient[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			cur_q       <= '0;
			known_q     <= 1'b0;
			co2_sum_q   <= '0;
			temp_sum_q  <= '0;
			humid_sum_q <= '0;
			count_q     <= '0;
			zcnt_q      <= '0;
			dsel_q      <= DSEL_CO2;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			if ((state_q == S_DONE) && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						dsel_q <= DSEL_CO2;
						case (cmd)
							bahr_pkg::CMD_SAMPLE: begin
								if (ignore || (same_bkt && (count_q == COUNT_MAX))) begin
									state_q <= S_DONE;
								end else if (same_bkt) begin
									co2_sum_q   <= co2_sum_q + bahr_pkg::CSUM_W'(co2_in);
									temp_sum_q  <= temp_sum_q + bahr_pkg::TSUM_W'(temp_in);
									humid_sum_q <= humid_sum_q + bahr_pkg::HSUM_W'(humid_in);
									count_q     <= count_q + 1'b1;
									state_q     <= S_DIV_GO;
								end else begin
									co2_sum_q   <= bahr_pkg::CSUM_W'(co2_in);
									temp_sum_q  <= bahr_pkg::TSUM_W'(temp_in);
									humid_sum_q <= bahr_pkg::HSUM_W'(humid_in);
									count_q     <= CB'(1);
									known_q     <= 1'b1;
									cur_q       <= bkt_p;
									zcnt_q      <= diff;
									state_q     <= known_q ? S_ZERO : S_DIV_GO;
								end
							end
							bahr_pkg::CMD_READ: begin
								state_q <= idx_bad ? S_DONE : S_READ;
							end
							bahr_pkg::CMD_LOAD: begin
								state_q <= S_DONE;
							end
							bahr_pkg::CMD_CLEAR: begin
								valid_q <= '0;
								wp_q    <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_ZERO: begin
					// skipped slot reads as zero once its valid bit drops
					valid_q[wp_q] <= 1'b0;
					wp_q          <= wp_next;
					zcnt_q        <= zcnt_q - 1'b1;
					if (zcnt_q == PW'(1)) begin
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (dsel_q == DSEL_HUMID) begin
							state_q <= S_WRITE;
						end else begin
							dsel_q  <= dsel_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_WRITE: begin
					state_q <= S_DONE;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_DIV_GO && dsel_q == DSEL_TEMP) begin
			tneg_q <= temp_sum_q[bahr_pkg::TSUM_W-1];
		end
		if (state_q == S_DIV_WAIT && div_rsp.done) begin
			case (dsel_q)
				DSEL_CO2:   mean_q.co2   <= div_rsp.quotient[15:0];
				DSEL_TEMP:  mean_q.temp  <= tq;
				DSEL_HUMID: mean_q.humid <= div_rsp.quotient[13:0];
				default:    mean_q.co2   <= mean_q.co2;
			endcase
		end
		case (state_q)
			S_IDLE: begin
				if (acc && (cmd == bahr_pkg::CMD_LOAD) && !idx_bad) begin
					res_rec_q <= '{humid: humid_in, temp: temp_in, co2: co2_in};
				end else begin
					res_rec_q <= '0;
				end
				if (!acc) begin
					res_stat_q <= bahr_pkg::STAT_DONE;
				end else begin
					case (cmd)
						bahr_pkg::CMD_SAMPLE: begin
							res_stat_q <= (ignore || (same_bkt && (count_q == COUNT_MAX)))
							              ? bahr_pkg::STAT_IGNORED : bahr_pkg::STAT_DONE;
						end
						bahr_pkg::CMD_READ, bahr_pkg::CMD_LOAD: begin
							res_stat_q <= idx_bad ? bahr_pkg::STAT_RANGE : bahr_pkg::STAT_DONE;
						end
						default: res_stat_q <= bahr_pkg::STAT_DONE;
					endcase
				end
			end
			S_WRITE: res_rec_q <= mean_q;
			S_READ:  res_rec_q <= rd_valid_s1 ? rd_data_s1 : '0;
			S_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_rec_q  <= res_rec_q;
					out_stat_q <= res_stat_q;
				end
			end
			default: res_rec_q <= res_rec_q;
		endcase
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_rec_q.humid, out_rec_q.temp, out_rec_q.co2};
	assign m_axis_tuser  = out_stat_q;

	`BAHR_ASSERT_SAME(a_div_done_waited, div_rsp.done, state_q == S_DIV_WAIT)
	`BAHR_ASSERT_SAME(a_zero_walk_count, state_q == S_ZERO, zcnt_q != '0)
	`BAHR_ASSERT_SAME(a_div_nonzero_divisor, state_q == S_DIV_GO, count_q != '0 && !div_rsp.busy)
	`BAHR_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
